@@ hdl/dur_pkg.sv @@
package dur_pkg;

    // Queue between the classifier and the parser
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // Fixed field widths
    localparam int CHAR_W      = 8;
    localparam int STATUS_W    = 3;
    localparam int SECONDS_W   = 31;
    localparam int DEFAULT_W   = 31;
    localparam int UNIT_SECS_W = 29;
    localparam int OUT_TDATA_W = 40;
    localparam int UNIT_COUNT  = 8;

    // Character codes
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BLANK    = 3'd1,
        ST_INVALID  = 3'd2,
        ST_COLONS   = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CF_HOURS   = 2'd0,
        CF_MINUTES = 2'd1,
        CF_SECONDS = 2'd2,
        CF_BEYOND  = 2'd3
    } colon_field_t;

    // One classified character
    typedef struct packed {
        logic [7:0] ch;
        logic       ws;
        logic       dig;
        logic [3:0] dval;
        logic       alcom;
        logic       colon;
        logic       last;
    } dur_item_t;

    // Control half of a finish request
    typedef struct packed {
        status_t status;
        logic    mul;
    } fin_ctl_t;

    // Unit word text, left aligned, zero filled
    function automatic logic [7:0] unit_char(input logic [2:0] idx, input logic [2:0] pos);
        logic [63:0] txt;
        logic [5:0]  bit_pos;
        case (idx)
            3'd0: txt = {"sec", 40'h0};
            3'd1: txt = {"min", 40'h0};
            3'd2: txt = {"hour", 32'h0};
            3'd3: txt = {"day", 40'h0};
            3'd4: txt = {"week", 32'h0};
            3'd5: txt = {"month", 24'h0};
            3'd6: txt = {"year", 32'h0};
            default: txt = {"forever", 8'h0};
        endcase
        bit_pos = {3'd7 - pos, 3'b000};
        return txt[bit_pos +: 8];
    endfunction

    function automatic logic [2:0] unit_len(input logic [2:0] idx);
        case (idx)
            3'd0: return 3'd3;
            3'd1: return 3'd3;
            3'd2: return 3'd4;
            3'd3: return 3'd3;
            3'd4: return 3'd4;
            3'd5: return 3'd5;
            3'd6: return 3'd4;
            default: return 3'd7;
        endcase
    endfunction

    function automatic logic [UNIT_SECS_W-1:0] unit_secs(input logic [2:0] idx);
        case (idx)
            3'd0: return 29'd1;
            3'd1: return 29'd60;
            3'd2: return 29'd3600;
            3'd3: return 29'd86400;
            3'd4: return 29'd604800;
            3'd5: return 29'd2592000;
            3'd6: return 29'd31536000;
            default: return 29'd315360000;
        endcase
    endfunction

    function automatic logic [UNIT_SECS_W-1:0] field_weight(input colon_field_t cf);
        case (cf)
            CF_HOURS:   return 29'd3600;
            CF_MINUTES: return 29'd60;
            CF_SECONDS: return 29'd1;
            default:    return 29'd0;
        endcase
    endfunction

endpackage

@@ hdl/dur_front.sv @@
module dur_front (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dur_pkg::CHAR_W-1:0]     s_tdata,   // [7:0] ch
    input  logic                           s_tlast,
    output logic                           push_valid,
    input  logic                           push_ready,
    output dur_pkg::dur_item_t             push_item
);

    logic [7:0] c;

    // Fold upper case letters
    always_comb begin
        c = s_tdata;
        if (s_tdata >= dur_pkg::CHAR_UP_A && s_tdata <= dur_pkg::CHAR_UP_Z) begin
            c = s_tdata | dur_pkg::CASE_BIT;
        end
    end

    // Classify the character
    always_comb begin
        push_item.ch    = c;
        push_item.ws    = (c <= dur_pkg::CHAR_SPACE);
        push_item.dig   = (c >= dur_pkg::CHAR_ZERO) && (c <= dur_pkg::CHAR_NINE);
        push_item.dval  = c[3:0];
        push_item.alcom = ((c >= dur_pkg::CHAR_LO_A) && (c <= dur_pkg::CHAR_LO_Z))
                          || (c == dur_pkg::CHAR_COMMA);
        push_item.colon = (c == dur_pkg::CHAR_COLON);
        push_item.last  = s_tlast;
    end

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

@@ hdl/dur_fifo.sv @@
module dur_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  dur_pkg::dur_item_t wr_item,
    output logic               rd_valid,
    input  logic               rd_ready,
    output dur_pkg::dur_item_t rd_item
);

    localparam int DEPTH = dur_pkg::QUEUE_DEPTH;
    localparam int PW    = dur_pkg::QUEUE_PTR_W;

    dur_pkg::dur_item_t mem_reg [DEPTH];
    logic [PW-1:0]      wr_ptr_reg;
    logic [PW-1:0]      rd_ptr_reg;
    logic [PW:0]        count_reg;
    logic               push;
    logic               pop;

    assign wr_ready = (count_reg != (PW+1)'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Store the beat
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + (PW+1)'(1);
                2'b01:   count_reg <= count_reg - (PW+1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ hdl/dur_back.sv @@
module dur_back #(
    parameter int TOTAL_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [dur_pkg::DEFAULT_W-1:0]   cfg_wr_data,
    input  logic                            rd_valid,
    output logic                            rd_ready,
    input  dur_pkg::dur_item_t              rd_item,
    output logic                            fin_valid,
    input  logic                            fin_ready,
    output dur_pkg::fin_ctl_t               fin_ctl,
    output logic [TOTAL_WIDTH-2:0]          fin_num,
    output logic [dur_pkg::DEFAULT_W-1:0]   fin_weight,
    output logic [TOTAL_WIDTH-2:0]          fin_total
);

    localparam int NW  = TOTAL_WIDTH - 1;
    localparam int UW  = dur_pkg::UNIT_SECS_W;
    localparam int NU  = dur_pkg::UNIT_COUNT;

    typedef enum logic [5:0] {
        PH_LEAD   = 6'b000001,
        PH_GSTART = 6'b000010,
        PH_NUM    = 6'b000100,
        PH_MATCH  = 6'b001000,
        PH_SUFFIX = 6'b010000,
        PH_ERR    = 6'b100000
    } phase_t;

    phase_t                    phase_reg, phase_next, step_phase;
    logic [NW-1:0]             num_reg, num_next, step_num;
    logic [NW-1:0]             tot_reg, tot_next, step_tot;
    dur_pkg::colon_field_t     cf_reg, cf_next, step_cf;
    logic                      first_reg, first_next, step_first;
    logic [NU-1:0]             cand_reg, cand_next, step_cand;
    logic [2:0]                mpos_reg, mpos_next, step_mpos;
    logic                      sp_reg, sp_next, step_sp;
    dur_pkg::status_t          err_reg, err_next, step_err;
    logic [dur_pkg::DEFAULT_W-1:0] default_reg;

    logic                      pop;
    logic                      do_group, num_digit, num_decide, do_decide;
    logic                      do_field, do_match;
    logic [NU-1:0]             cand_eff, keep;
    logic [2:0]                pos_eff, pos_inc;
    logic                      hit;
    logic [2:0]                hit_idx;
    logic [NW-1:0]             n_eff;
    logic [UW-1:0]             w_sel;
    logic [NW+UW-1:0]          prod;
    logic [NW+UW:0]            sum;
    logic                      mul_ovf;
    logic [NW+3:0]             acc10;
    logic                      dig_ovf;

    // Pop unless a final beat waits for the finish stage
    assign pop       = rd_valid && (!rd_item.last || fin_ready);
    assign rd_ready  = !rd_item.last || fin_ready;
    assign fin_valid = rd_valid && rd_item.last;

    // Decode what this beat does in the current phase
    always_comb begin
        do_group   = ((phase_reg == PH_LEAD) && !rd_item.ws) || (phase_reg == PH_GSTART)
                     || ((phase_reg == PH_SUFFIX) && !rd_item.alcom);
        num_digit  = (phase_reg == PH_NUM) && rd_item.dig && !sp_reg;
        num_decide = (phase_reg == PH_NUM) && !rd_item.ws && !num_digit;
        do_decide  = (do_group && !rd_item.ws && !rd_item.dig) || num_decide;
        do_field   = do_decide && rd_item.colon;
        do_match   = (do_decide && !rd_item.colon) || (phase_reg == PH_MATCH);
        n_eff      = ((phase_reg == PH_NUM) || (phase_reg == PH_MATCH)) ? num_reg : '0;
    end

    // Narrow the unit word candidates
    always_comb begin
        cand_eff = do_decide ? '1 : cand_reg;
        pos_eff  = do_decide ? 3'd0 : mpos_reg;
        pos_inc  = pos_eff + 3'd1;
        hit      = 1'b0;
        hit_idx  = 3'd0;
        for (int i = 0; i < NU; i++) begin
            keep[i] = cand_eff[i] && (pos_eff < dur_pkg::unit_len(3'(i)))
                      && (dur_pkg::unit_char(3'(i), pos_eff) == rd_item.ch);
        end
        for (int i = NU - 1; i >= 0; i--) begin
            if (keep[i] && (dur_pkg::unit_len(3'(i)) == pos_inc)) begin
                hit     = 1'b1;
                hit_idx = 3'(i);
            end
        end
    end

    // Shared multiply-add with saturation check
    always_comb begin
        w_sel   = do_field ? dur_pkg::field_weight(cf_reg) : dur_pkg::unit_secs(hit_idx);
        prod    = (NW+UW)'(n_eff) * (NW+UW)'(w_sel);
        sum     = (NW+UW+1)'(tot_reg) + (NW+UW+1)'(prod);
        mul_ovf = |sum[NW+UW:NW];
        acc10   = (NW+4)'({num_reg, 3'b000}) + (NW+4)'({num_reg, 1'b0})
                  + (NW+4)'(rd_item.dval);
        dig_ovf = |acc10[NW+3:NW];
    end

    // Apply one beat to the parse state
    always_comb begin
        step_phase = phase_reg;
        step_num   = num_reg;
        step_tot   = tot_reg;
        step_cf    = cf_reg;
        step_first = first_reg;
        step_cand  = cand_reg;
        step_mpos  = mpos_reg;
        step_sp    = sp_reg;
        step_err   = err_reg;
        if (do_group) begin
            step_num = '0;
            step_sp  = 1'b0;
            if (rd_item.ws) begin
                step_phase = PH_GSTART;
            end else if (rd_item.dig) begin
                step_num   = NW'(rd_item.dval);
                step_phase = PH_NUM;
            end
        end
        if (phase_reg == PH_NUM) begin
            if (rd_item.ws) begin
                step_sp = 1'b1;
            end else if (num_digit) begin
                if (dig_ovf) begin
                    step_err   = dur_pkg::ST_OVERFLOW;
                    step_phase = PH_ERR;
                end else begin
                    step_num = acc10[NW-1:0];
                end
            end
        end
        if (do_decide) begin
            step_first = 1'b0;
        end
        if (do_field) begin
            if (cf_reg == dur_pkg::CF_BEYOND) begin
                step_err   = dur_pkg::ST_COLONS;
                step_phase = PH_ERR;
            end else if (mul_ovf) begin
                step_err   = dur_pkg::ST_OVERFLOW;
                step_phase = PH_ERR;
            end else begin
                step_tot   = sum[NW-1:0];
                step_cf    = dur_pkg::colon_field_t'(cf_reg + 2'd1);
                step_num   = '0;
                step_sp    = 1'b0;
                step_phase = PH_GSTART;
            end
        end
        if (do_match) begin
            step_cand = keep;
            step_mpos = pos_inc;
            if (keep == '0) begin
                step_err   = dur_pkg::ST_INVALID;
                step_phase = PH_ERR;
            end else if (hit) begin
                if (mul_ovf) begin
                    step_err   = dur_pkg::ST_OVERFLOW;
                    step_phase = PH_ERR;
                end else begin
                    step_tot   = sum[NW-1:0];
                    step_num   = '0;
                    step_phase = PH_SUFFIX;
                end
            end else begin
                step_phase = PH_MATCH;
            end
        end
    end

    // Close the text on the final beat
    always_comb begin
        fin_ctl.status = step_err;
        fin_ctl.mul    = 1'b0;
        fin_num        = step_num;
        fin_total      = step_tot;
        fin_weight     = default_reg;
        case (step_phase)
            PH_LEAD: begin
                fin_ctl.status = dur_pkg::ST_BLANK;
            end
            PH_NUM: begin
                if (step_first) begin
                    fin_ctl.mul = 1'b1;
                end else if (step_cf == dur_pkg::CF_BEYOND) begin
                    fin_ctl.status = dur_pkg::ST_COLONS;
                end else begin
                    fin_ctl.mul = 1'b1;
                    fin_weight  = dur_pkg::DEFAULT_W'(dur_pkg::field_weight(step_cf));
                end
            end
            PH_MATCH: begin
                fin_ctl.status = dur_pkg::ST_INVALID;
            end
            default: begin
                fin_ctl.mul = 1'b0;
            end
        endcase
    end

    // Clear the parse state after the final beat
    always_comb begin
        if (pop && rd_item.last) begin
            phase_next = PH_LEAD;
            num_next   = '0;
            tot_next   = '0;
            cf_next    = dur_pkg::CF_HOURS;
            first_next = 1'b1;
            cand_next  = '1;
            mpos_next  = 3'd0;
            sp_next    = 1'b0;
            err_next   = dur_pkg::ST_OK;
        end else if (pop) begin
            phase_next = step_phase;
            num_next   = step_num;
            tot_next   = step_tot;
            cf_next    = step_cf;
            first_next = step_first;
            cand_next  = step_cand;
            mpos_next  = step_mpos;
            sp_next    = step_sp;
            err_next   = step_err;
        end else begin
            phase_next = phase_reg;
            num_next   = num_reg;
            tot_next   = tot_reg;
            cf_next    = cf_reg;
            first_next = first_reg;
            cand_next  = cand_reg;
            mpos_next  = mpos_reg;
            sp_next    = sp_reg;
            err_next   = err_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_LEAD;
            num_reg     <= '0;
            tot_reg     <= '0;
            cf_reg      <= dur_pkg::CF_HOURS;
            first_reg   <= 1'b1;
            cand_reg    <= '1;
            mpos_reg    <= 3'd0;
            sp_reg      <= 1'b0;
            err_reg     <= dur_pkg::ST_OK;
            default_reg <= dur_pkg::DEFAULT_W'(1);
        end else begin
            phase_reg <= phase_next;
            num_reg   <= num_next;
            tot_reg   <= tot_next;
            cf_reg    <= cf_next;
            first_reg <= first_next;
            cand_reg  <= cand_next;
            mpos_reg  <= mpos_next;
            sp_reg    <= sp_next;
            err_reg   <= err_next;
            if (cfg_wr_en) begin
                default_reg <= cfg_wr_data;
            end
        end
    end

endmodule

@@ hdl/dur_finish.sv @@
module dur_finish #(
    parameter int TOTAL_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  dur_pkg::fin_ctl_t                 req_ctl,
    input  logic [TOTAL_WIDTH-2:0]            req_num,
    input  logic [dur_pkg::DEFAULT_W-1:0]     req_weight,
    input  logic [TOTAL_WIDTH-2:0]            req_total,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dur_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    localparam int NW = TOTAL_WIDTH - 1;
    localparam int PW = NW + dur_pkg::DEFAULT_W;
    localparam int SW = PW + 1;

    logic                              a_valid_reg;
    dur_pkg::fin_ctl_t                 a_ctl_reg;
    logic [NW-1:0]                     a_num_reg;
    logic [dur_pkg::DEFAULT_W-1:0]     a_weight_reg;
    logic [NW-1:0]                     a_total_reg;

    logic                              b_valid_reg;
    dur_pkg::fin_ctl_t                 b_ctl_reg;
    logic [PW-1:0]                     b_prod_reg;
    logic [NW-1:0]                     b_total_reg;

    logic                              out_valid_reg;
    dur_pkg::status_t                  out_status_reg;
    logic [dur_pkg::SECONDS_W-1:0]     out_seconds_reg;

    logic                              out_free, b_free, a_free;
    logic [SW-1:0]                     sum;
    dur_pkg::status_t                  status_next;
    logic [NW-1:0]                     value;
    logic [63:0]                       value_wide;

    assign out_free  = !out_valid_reg || m_tready;
    assign b_free    = !b_valid_reg || out_free;
    assign a_free    = !a_valid_reg || b_free;
    assign req_ready = a_free;

    // Resolve the final sum and saturate
    always_comb begin
        sum         = SW'(b_total_reg) + SW'(b_prod_reg);
        status_next = b_ctl_reg.status;
        value       = b_total_reg;
        if (b_ctl_reg.status == dur_pkg::ST_OVERFLOW) begin
            value = '1;
        end else if (b_ctl_reg.status != dur_pkg::ST_OK) begin
            value = '0;
        end else if (b_ctl_reg.mul) begin
            if (|sum[SW-1:NW]) begin
                status_next = dur_pkg::ST_OVERFLOW;
                value       = '1;
            end else begin
                value = sum[NW-1:0];
            end
        end
        value_wide = 64'(value);
    end

    // Advance the request, product and output stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (a_free) begin
                a_valid_reg <= req_valid;
            end
            if (b_free) begin
                b_valid_reg <= a_valid_reg;
            end
            if (out_free) begin
                out_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_free && req_valid) begin
            a_ctl_reg    <= req_ctl;
            a_num_reg    <= req_num;
            a_weight_reg <= req_weight;
            a_total_reg  <= req_total;
        end
        if (b_free && a_valid_reg) begin
            b_ctl_reg   <= a_ctl_reg;
            b_prod_reg  <= PW'(a_num_reg) * PW'(a_weight_reg);
            b_total_reg <= a_total_reg;
        end
        if (out_free && b_valid_reg) begin
            out_status_reg  <= status_next;
            out_seconds_reg <= value_wide[dur_pkg::SECONDS_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {
        (dur_pkg::OUT_TDATA_W - dur_pkg::SECONDS_W - dur_pkg::STATUS_W)'(0),
        out_seconds_reg, out_status_reg
    };

endmodule

@@ hdl/duration_spec_parser.sv @@
// Duration text parser.
// Input stream: one character per beat in s_tdata[7:0], s_tlast on the final
// character of a text. Letters are case folded, whitespace is any code up to
// 32. Output stream: one beat per text, m_tdata[2:0] status (ok, blank,
// invalid specifier, too many colons, overflow) and m_tdata[33:3] seconds.
// Overflow saturates seconds at 2^(TOTAL_WIDTH-1)-1, masked to 31 bits.
// cfg_wr_en/cfg_wr_data set the seconds per unit for a lone number (reset 1);
// write it only while no text is in flight.
// Throughput: one character per cycle while the output does not stall. A
// classifier feeds a four-entry queue, the parser takes one queued character
// per cycle with one multiply-add, holding a final character while the finish
// stage is full, and a three-register finish pipeline multiplies the last
// number by its weight in its request, product and output registers.
// Reset clears the parse state and all queues; the unit returns to 1.
// When m_tready is low, the finish pipeline and then the queue fill, after
// which s_tready drops; no beat is lost.
module duration_spec_parser #(
    parameter int TOTAL_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [dur_pkg::DEFAULT_W-1:0]     cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dur_pkg::CHAR_W-1:0]        s_tdata,   // [7:0] ch
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dur_pkg::OUT_TDATA_W-1:0]   m_tdata    // [2:0] status, [33:3] seconds
);

    logic                            push_valid, push_ready;
    dur_pkg::dur_item_t              push_item;
    logic                            pop_valid, pop_ready;
    dur_pkg::dur_item_t              pop_item;
    logic                            fin_valid, fin_ready;
    dur_pkg::fin_ctl_t               fin_ctl;
    logic [TOTAL_WIDTH-2:0]          fin_num;
    logic [dur_pkg::DEFAULT_W-1:0]   fin_weight;
    logic [TOTAL_WIDTH-2:0]          fin_total;

    dur_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    dur_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_item  (push_item),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_item  (pop_item)
    );

    dur_back #(
        .TOTAL_WIDTH (TOTAL_WIDTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rd_valid    (pop_valid),
        .rd_ready    (pop_ready),
        .rd_item     (pop_item),
        .fin_valid   (fin_valid),
        .fin_ready   (fin_ready),
        .fin_ctl     (fin_ctl),
        .fin_num     (fin_num),
        .fin_weight  (fin_weight),
        .fin_total   (fin_total)
    );

    dur_finish #(
        .TOTAL_WIDTH (TOTAL_WIDTH)
    ) u_finish (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (fin_valid),
        .req_ready  (fin_ready),
        .req_ctl    (fin_ctl),
        .req_num    (fin_num),
        .req_weight (fin_weight),
        .req_total  (fin_total),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

`ifndef SYNTHESIS
    localparam logic [63:0] LIMIT_WIDE = (64'd1 << (TOTAL_WIDTH - 1)) - 64'd1;

    // Error results other than overflow carry no seconds
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == dur_pkg::ST_BLANK || m_tdata[2:0] == dur_pkg::ST_INVALID
                     || m_tdata[2:0] == dur_pkg::ST_COLONS)
        |-> m_tdata[33:3] == '0)
        else $error("error result with nonzero seconds");

    // Overflow results carry the saturation limit
    a_overflow_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == dur_pkg::ST_OVERFLOW)
        |-> m_tdata[33:3] == LIMIT_WIDE[dur_pkg::SECONDS_W-1:0])
        else $error("overflow result not saturated");

    // A final character held by the parser is not dropped while finish stalls
    a_final_held: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_valid && !fin_ready |=> fin_valid)
        else $error("final character lost while finish stage stalled");
`endif

endmodule
